// ===== rtl/core/sts_pkg.sv =====
// Package: token scanner constants, types and byte class helpers.
`default_nettype none
package sts_pkg;

  localparam int POSITION_BITS = 16;
  localparam int LENGTH_BITS   = 16;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};

  // scan modes
  localparam logic [3:0] M_IDLE     = 4'd0;
  localparam logic [3:0] M_IDENT    = 4'd1;
  localparam logic [3:0] M_ZERO     = 4'd2;
  localparam logic [3:0] M_DEC      = 4'd3;
  localparam logic [3:0] M_SUFFIX   = 4'd4;
  localparam logic [3:0] M_HEX      = 4'd5;
  localparam logic [3:0] M_BIN      = 4'd6;
  localparam logic [3:0] M_OCT      = 4'd7;
  localparam logic [3:0] M_COMMENT  = 4'd8;
  localparam logic [3:0] M_LT       = 4'd9;
  localparam logic [3:0] M_GT       = 4'd10;
  localparam logic [3:0] M_EQ       = 4'd11;
  localparam logic [3:0] M_BANG     = 4'd12;
  localparam logic [3:0] M_CH_OPEN  = 4'd13;
  localparam logic [3:0] M_CH_ESC   = 4'd14;
  localparam logic [3:0] M_CH_CLOSE = 4'd15;

  // token kinds
  localparam logic [4:0] K_EOF    = 5'd0;
  localparam logic [4:0] K_IDENT  = 5'd1;
  localparam logic [4:0] K_KW0    = 5'd2;
  localparam logic [4:0] K_NUMBER = 5'd11;
  localparam logic [4:0] K_CHAR   = 5'd12;
  localparam logic [4:0] K_PUNCT0 = 5'd13;
  localparam logic [4:0] K_BINOP  = 5'd20;
  localparam logic [4:0] K_ASSIGN = 5'd21;
  localparam logic [4:0] K_UNOP   = 5'd22;
  localparam logic [4:0] K_ERROR  = 5'd23;

  // binop details
  localparam logic [7:0] OP_LT = 8'd5;
  localparam logic [7:0] OP_LE = 8'd6;
  localparam logic [7:0] OP_GT = 8'd7;
  localparam logic [7:0] OP_GE = 8'd8;
  localparam logic [7:0] OP_EQ = 8'd9;
  localparam logic [7:0] OP_NE = 8'd10;

  // error codes
  localparam logic [3:0] E_NONE      = 4'd0;
  localparam logic [3:0] E_HEX_FLT   = 4'd1;
  localparam logic [3:0] E_BIN_DIG   = 4'd2;
  localparam logic [3:0] E_BIN_FLT   = 4'd3;
  localparam logic [3:0] E_OCT_DIG   = 4'd4;
  localparam logic [3:0] E_OCT_FLT   = 4'd5;
  localparam logic [3:0] E_EMPTY_CH  = 4'd6;
  localparam logic [3:0] E_BAD_ESC   = 4'd7;
  localparam logic [3:0] E_NO_APOS   = 4'd8;
  localparam logic [3:0] E_INVALID   = 4'd9;

  localparam int NUM_KW = 9;

  typedef struct packed {
    logic [4:0]               kind;
    logic [7:0]               detail;
    logic [POSITION_BITS-1:0] row;
    logic [POSITION_BITS-1:0] col;
    logic [LENGTH_BITS-1:0]   len;
    logic [3:0]               err;
  } token_t;

  // keyword character at position i (0 when past the end)
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] i);
    logic [7:0] ch;
    ch = 8'd0;
    case (k)
      4'd0: case (i) 4'd0: ch = "f"; 4'd1: ch = "n"; default: ch = 8'd0; endcase
      4'd1: case (i) 4'd0: ch = "p"; 4'd1: ch = "u"; 4'd2: ch = "b"; default: ch = 8'd0; endcase
      4'd2: case (i) 4'd0: ch = "r"; 4'd1: ch = "e"; 4'd2: ch = "t"; default: ch = 8'd0; endcase
      4'd3: case (i) 4'd0: ch = "v"; 4'd1: ch = "a"; 4'd2: ch = "r"; default: ch = 8'd0; endcase
      4'd4: case (i) 4'd0: ch = "i"; 4'd1: ch = "f"; default: ch = 8'd0; endcase
      4'd5: case (i)
        4'd0: ch = "e"; 4'd1: ch = "l"; 4'd2: ch = "s"; 4'd3: ch = "e";
        default: ch = 8'd0;
      endcase
      4'd6: case (i)
        4'd0: ch = "w"; 4'd1: ch = "h"; 4'd2: ch = "i"; 4'd3: ch = "l"; 4'd4: ch = "e";
        default: ch = 8'd0;
      endcase
      4'd7: case (i)
        4'd0: ch = "b"; 4'd1: ch = "r"; 4'd2: ch = "e"; 4'd3: ch = "a"; 4'd4: ch = "k";
        default: ch = 8'd0;
      endcase
      4'd8: case (i)
        4'd0: ch = "c"; 4'd1: ch = "o"; 4'd2: ch = "n"; 4'd3: ch = "t";
        4'd4: ch = "i"; 4'd5: ch = "n"; 4'd6: ch = "u"; 4'd7: ch = "e";
        default: ch = 8'd0;
      endcase
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      4'd0, 4'd4: n = 4'd2;
      4'd1, 4'd2, 4'd3: n = 4'd3;
      4'd5: n = 4'd4;
      4'd6, 4'd7: n = 4'd5;
      4'd8: n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction
  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sts_in_if.sv =====
// Interface: input byte channel.
`default_nettype none
interface sts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;
  modport source (output valid, char_byte, end_of_input, input ready);
  modport sink (input valid, char_byte, end_of_input, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sts_out_if.sv =====
// Interface: output token channel.
`default_nettype none
interface sts_out_if;
  logic                              valid;
  logic                              ready;
  logic [4:0]                        token_kind;
  logic [7:0]                        token_detail;
  logic [sts_pkg::POSITION_BITS-1:0] start_row;
  logic [sts_pkg::POSITION_BITS-1:0] start_column;
  logic [sts_pkg::LENGTH_BITS-1:0]   token_length;
  logic [3:0]                        error_code;
  logic                              last_of_run;
  modport source (output valid, token_kind, token_detail, start_row, start_column,
                  token_length, error_code, last_of_run, input ready);
  modport sink (input valid, token_kind, token_detail, start_row, start_column,
                token_length, error_code, last_of_run, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sts_lexer.sv =====
// Lexer step: scanner state registers and the per-byte next-state logic.
`default_nettype none
module sts_lexer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                step,
  input  wire logic [7:0]          c,
  input  wire logic                eoi,
  output sts_pkg::token_t          tok0,
  output sts_pkg::token_t          tok1,
  output logic [1:0]               count
);
  import sts_pkg::*;

  logic [3:0]               scan_mode, scan_mode_next;
  logic [NUM_KW-1:0]        keyword_match, keyword_match_next;
  logic [LENGTH_BITS-1:0]   pending_length, pending_length_next;
  logic [POSITION_BITS-1:0] pending_row, pending_row_next;
  logic [POSITION_BITS-1:0] pending_column, pending_column_next;
  logic [POSITION_BITS-1:0] current_row, current_row_next;
  logic [POSITION_BITS-1:0] current_column, current_column_next;
  logic [7:0]               pending_value, pending_value_next;
  logic                     halted_on_error, halted_next;

  logic [LENGTH_BITS-1:0]   len_p1;
  logic                     taken;
  logic [4:0]               id_kind;

  token_t t_pend, t_start;
  logic   em_pend, em_start;

  assign len_p1 = (pending_length < LEN_MAX) ? pending_length + 1'b1 : LEN_MAX;

  // keyword resolution on the pending identifier
  always_comb begin
    id_kind = K_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (keyword_match[k] && pending_length == LENGTH_BITS'(kw_len(4'(k))))
        id_kind = K_KW0 + 5'(k);
    end
  end

  // keyword bits surviving byte c at position idx
  function automatic logic [NUM_KW-1:0] kw_filter(input logic [NUM_KW-1:0] m,
                                                  input logic [LENGTH_BITS-1:0] idx,
                                                  input logic [7:0] ch);
    logic [NUM_KW-1:0] r;
    r = m;
    for (int k = 0; k < NUM_KW; k++) begin
      if (idx >= LENGTH_BITS'(kw_len(4'(k))) || kw_char(4'(k), idx[3:0]) != ch)
        r[k] = 1'b0;
    end
    return r;
  endfunction

  always_comb begin
    scan_mode_next      = scan_mode;
    keyword_match_next  = keyword_match;
    pending_length_next = pending_length;
    pending_row_next    = pending_row;
    pending_column_next = pending_column;
    current_row_next    = current_row;
    current_column_next = current_column;
    pending_value_next  = pending_value;
    halted_next         = halted_on_error;
    em_pend  = 1'b0;
    em_start = 1'b0;
    taken    = 1'b1;
    t_pend   = '{kind: K_EOF, detail: 8'd0, row: pending_row, col: pending_column,
                 len: pending_length, err: E_NONE};
    t_start  = '{kind: K_EOF, detail: 8'd0, row: current_row, col: current_column,
                 len: LENGTH_BITS'(0), err: E_NONE};

    if (!halted_on_error) begin
      if (eoi) begin
        scan_mode_next = M_IDLE;
        case (scan_mode)
          M_IDENT: begin em_pend = 1'b1; t_pend.kind = id_kind; end
          M_ZERO, M_DEC, M_SUFFIX, M_HEX, M_BIN, M_OCT: begin
            em_pend = 1'b1; t_pend.kind = K_NUMBER;
          end
          M_LT: begin em_pend = 1'b1; t_pend.kind = K_BINOP; t_pend.detail = OP_LT;
            t_pend.len = LENGTH_BITS'(1); end
          M_GT: begin em_pend = 1'b1; t_pend.kind = K_BINOP; t_pend.detail = OP_GT;
            t_pend.len = LENGTH_BITS'(1); end
          M_EQ: begin em_pend = 1'b1; t_pend.kind = K_ASSIGN;
            t_pend.len = LENGTH_BITS'(1); end
          M_BANG: begin em_pend = 1'b1; t_pend.kind = K_UNOP;
            t_pend.len = LENGTH_BITS'(1); end
          M_CH_OPEN, M_CH_CLOSE: begin em_pend = 1'b1; t_pend.kind = K_ERROR;
            t_pend.err = E_NO_APOS; halted_next = 1'b1; end
          M_CH_ESC: begin em_pend = 1'b1; t_pend.kind = K_ERROR;
            t_pend.err = E_BAD_ESC; halted_next = 1'b1; end
          default: ;
        endcase
        // eof token unless the flush failed
        if (!halted_next) em_start = 1'b1;
      end else begin
        if (c == 8'h0A) begin
          if (current_row < POS_MAX) current_row_next = current_row + 1'b1;
          current_column_next = '0;
        end else if (current_column < POS_MAX) begin
          current_column_next = current_column + 1'b1;
        end

        // continue the pending token
        case (scan_mode)
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
              keyword_match_next  = kw_filter(keyword_match, pending_length, c);
              pending_length_next = len_p1;
            end else begin
              em_pend = 1'b1; t_pend.kind = id_kind; taken = 1'b0;
            end
          end
          M_ZERO, M_DEC: begin
            if (scan_mode == M_ZERO && c == "x") begin
              scan_mode_next = M_HEX; pending_length_next = len_p1;
            end else if (scan_mode == M_ZERO && c == "b") begin
              scan_mode_next = M_BIN; pending_length_next = len_p1;
            end else if (scan_mode == M_ZERO && c == "o") begin
              scan_mode_next = M_OCT; pending_length_next = len_p1;
            end else if (is_digit(c) || c == "." || c == "_") begin
              scan_mode_next = M_DEC; pending_length_next = len_p1;
            end else if (c == "i" || c == "u" || c == "f") begin
              scan_mode_next = M_SUFFIX; pending_length_next = len_p1;
            end else begin
              em_pend = 1'b1; t_pend.kind = K_NUMBER; taken = 1'b0;
            end
          end
          M_SUFFIX: begin
            if (is_digit(c)) pending_length_next = len_p1;
            else begin em_pend = 1'b1; t_pend.kind = K_NUMBER; taken = 1'b0; end
          end
          M_HEX: begin
            if (is_xdigit(c) || c == "_") pending_length_next = len_p1;
            else if (c == ".") begin
              em_pend = 1'b1; t_pend.kind = K_ERROR; t_pend.err = E_HEX_FLT;
              t_pend.len = len_p1; halted_next = 1'b1;
            end else if (c == "i" || c == "u") begin
              scan_mode_next = M_SUFFIX; pending_length_next = len_p1;
            end else begin em_pend = 1'b1; t_pend.kind = K_NUMBER; taken = 1'b0; end
          end
          M_BIN, M_OCT: begin
            if ((c >= "0" && c <= ((scan_mode == M_BIN) ? "1" : "7")) || c == "_")
              pending_length_next = len_p1;
            else if (is_digit(c)) begin
              em_pend = 1'b1; t_pend.kind = K_ERROR; t_pend.len = len_p1;
              t_pend.err = (scan_mode == M_BIN) ? E_BIN_DIG : E_OCT_DIG;
              halted_next = 1'b1;
            end else if (c == "." || c == "f") begin
              em_pend = 1'b1; t_pend.kind = K_ERROR; t_pend.len = len_p1;
              t_pend.err = (scan_mode == M_BIN) ? E_BIN_FLT : E_OCT_FLT;
              halted_next = 1'b1;
            end else if (c == "i" || c == "u") begin
              scan_mode_next = M_SUFFIX; pending_length_next = len_p1;
            end else begin em_pend = 1'b1; t_pend.kind = K_NUMBER; taken = 1'b0; end
          end
          M_COMMENT: begin
            if (c == 8'h0A || c == 8'h0D) scan_mode_next = M_IDLE;
          end
          M_LT, M_GT, M_EQ, M_BANG: begin
            em_pend = 1'b1;
            if (c == "=") begin
              t_pend.kind = K_BINOP; t_pend.len = LENGTH_BITS'(2);
              case (scan_mode)
                M_LT:    t_pend.detail = OP_LE;
                M_GT:    t_pend.detail = OP_GE;
                M_EQ:    t_pend.detail = OP_EQ;
                default: t_pend.detail = OP_NE;
              endcase
            end else begin
              taken = 1'b0; t_pend.len = LENGTH_BITS'(1);
              case (scan_mode)
                M_LT:    begin t_pend.kind = K_BINOP; t_pend.detail = OP_LT; end
                M_GT:    begin t_pend.kind = K_BINOP; t_pend.detail = OP_GT; end
                M_EQ:    t_pend.kind = K_ASSIGN;
                default: t_pend.kind = K_UNOP;
              endcase
            end
          end
          M_CH_OPEN: begin
            if (c == "'") begin
              em_pend = 1'b1; t_pend.kind = K_ERROR; t_pend.err = E_EMPTY_CH;
              t_pend.len = len_p1; halted_next = 1'b1;
            end else begin
              pending_length_next = len_p1;
              if (c == "\\") scan_mode_next = M_CH_ESC;
              else begin pending_value_next = c; scan_mode_next = M_CH_CLOSE; end
            end
          end
          M_CH_ESC: begin
            if (c == "0" || c == "n" || c == "'") begin
              pending_value_next = (c == "0") ? 8'd0 : (c == "n") ? 8'd10 : 8'd39;
              pending_length_next = len_p1;
              scan_mode_next = M_CH_CLOSE;
            end else begin
              em_pend = 1'b1; t_pend.kind = K_ERROR; t_pend.err = E_BAD_ESC;
              t_pend.len = len_p1; halted_next = 1'b1;
            end
          end
          M_CH_CLOSE: begin
            em_pend = 1'b1; t_pend.len = len_p1;
            if (c == "'") begin t_pend.kind = K_CHAR; t_pend.detail = pending_value; end
            else begin t_pend.kind = K_ERROR; t_pend.err = E_NO_APOS; halted_next = 1'b1; end
          end
          default: taken = 1'b0;
        endcase
        if (em_pend) scan_mode_next = M_IDLE;

        // start a new token with this byte
        if (!taken) begin
          scan_mode_next      = M_IDLE;
          pending_row_next    = current_row;
          pending_column_next = current_column;
          pending_length_next = LENGTH_BITS'(1);
          t_start.len         = LENGTH_BITS'(1);
          if (is_space(c)) begin
          end else if (is_alpha(c) || c == "_" || c == "@") begin
            keyword_match_next = kw_filter({NUM_KW{1'b1}}, '0, c);
            scan_mode_next = M_IDENT;
          end else if (is_digit(c)) scan_mode_next = (c == "0") ? M_ZERO : M_DEC;
          else if (c == "#")  scan_mode_next = M_COMMENT;
          else if (c == "'")  scan_mode_next = M_CH_OPEN;
          else if (c == "<")  scan_mode_next = M_LT;
          else if (c == ">")  scan_mode_next = M_GT;
          else if (c == "=")  scan_mode_next = M_EQ;
          else if (c == "!")  scan_mode_next = M_BANG;
          else begin
            em_start = 1'b1;
            case (c)
              ";": t_start.kind = K_PUNCT0;
              ",": t_start.kind = K_PUNCT0 + 5'd1;
              "{": t_start.kind = K_PUNCT0 + 5'd2;
              "}": t_start.kind = K_PUNCT0 + 5'd3;
              "(": t_start.kind = K_PUNCT0 + 5'd4;
              ")": t_start.kind = K_PUNCT0 + 5'd5;
              ":": t_start.kind = K_PUNCT0 + 5'd6;
              "*": begin t_start.kind = K_BINOP; t_start.detail = 8'd0; end
              "/": begin t_start.kind = K_BINOP; t_start.detail = 8'd1; end
              "+": begin t_start.kind = K_BINOP; t_start.detail = 8'd2; end
              "-": begin t_start.kind = K_BINOP; t_start.detail = 8'd3; end
              "%": begin t_start.kind = K_BINOP; t_start.detail = 8'd4; end
              default: begin
                t_start.kind = K_ERROR; t_start.err = E_INVALID; halted_next = 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    if (em_pend) begin
      tok0 = t_pend; tok1 = t_start;
    end else begin
      tok0 = t_start; tok1 = t_pend;
    end
    count = 2'(em_pend) + 2'(em_start);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= M_IDLE;
      keyword_match   <= '0;
      pending_length  <= '0;
      pending_row     <= '0;
      pending_column  <= '0;
      current_row     <= POSITION_BITS'(1);
      current_column  <= '0;
      pending_value   <= '0;
      halted_on_error <= 1'b0;
    end else if (step) begin
      scan_mode       <= scan_mode_next;
      keyword_match   <= keyword_match_next;
      pending_length  <= pending_length_next;
      pending_row     <= pending_row_next;
      pending_column  <= pending_column_next;
      current_row     <= current_row_next;
      current_column  <= current_column_next;
      pending_value   <= pending_value_next;
      halted_on_error <= halted_next;
    end
  end

  // once halted nothing is produced
  assert property (@(posedge clk) disable iff (rst) halted_on_error |-> count == 2'd0)
    else $error("tokens produced while halted");
  // an error token always halts the scanner
  assert property (@(posedge clk) disable iff (rst)
    step && count != 2'd0 && tok0.kind == K_ERROR |=> halted_on_error)
    else $error("error token without halt");
  // row never drops below one
  assert property (@(posedge clk) disable iff (rst) current_row != '0)
    else $error("row counter reached zero");

endmodule
`default_nettype wire

// ===== rtl/core/sts_out_buf.sv =====
// Output buffer: holds up to two tokens of one byte and drains them in order.
`default_nettype none
module sts_out_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  sts_pkg::token_t     tok0,
  input  sts_pkg::token_t     tok1,
  input  wire logic [1:0]     count,
  output logic                empty_next,
  sts_out_if.source           out
);
  import sts_pkg::*;

  token_t     slot0, slot1;
  logic [1:0] fill;
  logic       pop;

  assign pop = out.valid && out.ready;
  // after this cycle's pop, is the buffer free for a new load
  assign empty_next = (fill == 2'd0) || (fill == 2'd1 && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else if (load) begin
      fill <= count;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= tok0;
      slot1 <= tok1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  assign out.valid        = fill != 2'd0;
  assign out.token_kind   = slot0.kind;
  assign out.token_detail = slot0.detail;
  assign out.start_row    = slot0.row;
  assign out.start_column = slot0.col;
  assign out.token_length = slot0.len;
  assign out.error_code   = slot0.err;
  assign out.last_of_run  = fill == 2'd1;

  assert property (@(posedge clk) disable iff (rst) load |-> empty_next)
    else $error("load into busy buffer");
  assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("fill overflow");
  assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 && pop |=> fill == 2'd1)
    else $error("second token lost");

endmodule
`default_nettype wire

// ===== rtl/core/source_token_scanner_core.sv =====
// Top level: streaming source scanner producing one token item per output handshake.
//
// Usage:
//   in  : one source byte per item (char_byte), or an end mark (end_of_input=1)
//         that flushes the pending token and yields an eof token.
//   out : token items: kind, detail, start row/column, length, error code,
//         last_of_run marks the final token caused by one input item.
// Latency: tokens caused by a byte appear on out the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one token
//   and out is ready; a byte yielding two tokens holds in.ready low while
//   the second drains (set by the two-slot output buffer).
// Stalls: in.ready drops only while the output buffer still holds tokens
//   that the next load would overwrite; nothing is lost on a stalled out.
// Reset: synchronous; position goes to row 1 column 0, scanner idle,
//   buffer empty. After an error token the scanner takes bytes but emits
//   nothing until reset.
`default_nettype none
module source_token_scanner_core (
  input wire logic  clk,
  input wire logic  rst,
  sts_in_if.sink    in,
  sts_out_if.source out
);
  import sts_pkg::*;

  token_t     tok0, tok1;
  logic [1:0] count;
  logic       step;
  logic       empty_next;

  // accept when the buffer will be free after this cycle's drain
  assign in.ready = empty_next;
  assign step     = in.valid && in.ready;

  sts_lexer u_lexer (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .c     (in.char_byte),
    .eoi   (in.end_of_input),
    .tok0  (tok0),
    .tok1  (tok1),
    .count (count)
  );

  sts_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .tok0       (tok0),
    .tok1       (tok1),
    .count      (count),
    .empty_next (empty_next),
    .out        (out)
  );

  assert property (@(posedge clk) disable iff (rst)
    step && count != 2'd0 |=> out.valid)
    else $error("token not presented");
  assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> !in.ready || !out.last_of_run || out.valid)
    else $error("stall handling");
  assert property (@(posedge clk) disable iff (rst)
    step && count == 2'd0 |=> !out.valid)
    else $error("spurious token");

endmodule
`default_nettype wire

// ===== tb/sv/tb_source_token_scanner_core.sv =====
// Testbench: source token scanner, checked item by item against a predictor of the scanner.
`default_nettype none
module tb_source_token_scanner_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    token_t tok;
    logic   last;
  } token_item_t;

  logic clk;
  logic rst;
  sts_in_if  in_ch();
  sts_out_if out_ch();

  source_token_scanner_core DUT (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // tokens still owed by the scanner, oldest first
  token_item_t pending_tokens[$];
  int          mismatches  = 0;
  int          sender_idle = 0;   // percent of items preceded by a gap
  int          stall_rate  = 0;   // percent of cycles out.ready is low
  int          quiet_cycles = 0;

  // ---------------------------------------------------------------------
  // Scanner predictor: own copy of the scan state
  // ---------------------------------------------------------------------
  logic [3:0]  scan_mode;
  logic [8:0]  kw_alive;
  logic [15:0] tok_len, tok_row, tok_col, cur_row, cur_col;
  logic [7:0]  char_value;
  bit          halted;
  token_item_t step_tokens[2];
  int          step_count;

  string kw_words[9] = '{"fn", "pub", "ret", "var", "if", "else", "while", "break",
                         "continue"};
  string punct_chars = ";,{}():";
  string arith_chars = "*/+-%";

  function automatic bit cl_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction
  function automatic bit cl_alpha(logic [7:0] c);
    return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
  endfunction
  function automatic bit cl_hex(logic [7:0] c);
    return cl_digit(c) || (c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70);
  endfunction
  function automatic bit cl_space(logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void put_token(logic [4:0] kind, logic [7:0] detail, logic [15:0] row,
                                    logic [15:0] col, logic [15:0] len, logic [3:0] err);
    if (step_count < 2) begin
      step_tokens[step_count] = '{tok: '{kind, detail, row, col, len, err}, last: 1'b0};
      step_count++;
    end
  endfunction

  function automatic void grow_len();
    if (tok_len != LEN_MAX) tok_len++;
  endfunction

  function automatic logic [15:0] len_with_byte();
    return (tok_len != LEN_MAX) ? tok_len + 16'd1 : LEN_MAX;
  endfunction

  function automatic void close_token(logic [4:0] kind, logic [7:0] detail, logic [15:0] len);
    put_token(kind, detail, tok_row, tok_col, len, E_NONE);
    scan_mode = M_IDLE;
  endfunction

  function automatic void raise_error(logic [3:0] code, logic [15:0] len);
    put_token(K_ERROR, 8'd0, tok_row, tok_col, len, code);
    halted = 1'b1;
    scan_mode = M_IDLE;
  endfunction

  // drop keyword candidates that disagree with c at the current offset
  function automatic void narrow_keywords(logic [7:0] c);
    for (int k = 0; k < 9; k++)
      if (int'(tok_len) >= kw_words[k].len() || kw_words[k][int'(tok_len)] != c)
        kw_alive[k] = 1'b0;
  endfunction

  function automatic void close_ident();
    logic [4:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < 9; k++)
      if (kw_alive[k] && int'(tok_len) == kw_words[k].len()) kind = K_KW0 + 5'(k);
    close_token(kind, 8'd0, tok_len);
  endfunction

  function automatic void open_token(logic [7:0] c, logic [15:0] row, logic [15:0] col);
    tok_row = row;
    tok_col = col;
    tok_len = 16'd1;
    if (cl_space(c)) return;
    if (cl_alpha(c) || c == "_" || c == "@") begin
      kw_alive = 9'h1FF;
      tok_len = 16'd0;
      narrow_keywords(c);
      tok_len = 16'd1;
      scan_mode = M_IDENT;
      return;
    end
    if (cl_digit(c)) begin
      scan_mode = (c == "0") ? M_ZERO : M_DEC;
      return;
    end
    case (c)
      "#":   begin scan_mode = M_COMMENT; return; end
      8'd39: begin scan_mode = M_CH_OPEN; return; end
      "<":   begin scan_mode = M_LT; return; end
      ">":   begin scan_mode = M_GT; return; end
      "=":   begin scan_mode = M_EQ; return; end
      "!":   begin scan_mode = M_BANG; return; end
      default: ;
    endcase
    for (int k = 0; k < 7; k++)
      if (c == punct_chars[k]) begin close_token(K_PUNCT0 + 5'(k), 8'd0, 16'd1); return; end
    for (int k = 0; k < 5; k++)
      if (c == arith_chars[k]) begin close_token(K_BINOP, 8'(k), 16'd1); return; end
    raise_error(E_INVALID, 16'd1);
  endfunction

  // 1 when c was absorbed by the token in progress (or ended the scan)
  function automatic bit extend_token(logic [7:0] c);
    bit bin;
    if (scan_mode == M_ZERO) begin
      if (c == "x") begin scan_mode = M_HEX; grow_len(); return 1; end
      if (c == "b") begin scan_mode = M_BIN; grow_len(); return 1; end
      if (c == "o") begin scan_mode = M_OCT; grow_len(); return 1; end
    end
    case (scan_mode)
      M_IDENT: begin
        if (cl_alpha(c) || cl_digit(c) || c == "_") begin
          narrow_keywords(c); grow_len(); return 1;
        end
        close_ident();
        return 0;
      end
      M_ZERO, M_DEC: begin
        if (cl_digit(c) || c == "." || c == "_") begin scan_mode = M_DEC; grow_len(); return 1; end
        if (c == "i" || c == "u" || c == "f") begin scan_mode = M_SUFFIX; grow_len(); return 1; end
        close_token(K_NUMBER, 8'd0, tok_len);
        return 0;
      end
      M_SUFFIX: begin
        if (cl_digit(c)) begin grow_len(); return 1; end
        close_token(K_NUMBER, 8'd0, tok_len);
        return 0;
      end
      M_HEX: begin
        if (cl_hex(c) || c == "_") begin grow_len(); return 1; end
        if (c == ".") begin raise_error(E_HEX_FLT, len_with_byte()); return 1; end
        if (c == "i" || c == "u") begin scan_mode = M_SUFFIX; grow_len(); return 1; end
        close_token(K_NUMBER, 8'd0, tok_len);
        return 0;
      end
      M_BIN, M_OCT: begin
        bin = (scan_mode == M_BIN);
        if ((c >= "0" && c <= (bin ? "1" : "7")) || c == "_") begin grow_len(); return 1; end
        if (cl_digit(c)) begin
          raise_error(bin ? E_BIN_DIG : E_OCT_DIG, len_with_byte()); return 1;
        end
        if (c == "." || c == "f") begin
          raise_error(bin ? E_BIN_FLT : E_OCT_FLT, len_with_byte()); return 1;
        end
        if (c == "i" || c == "u") begin scan_mode = M_SUFFIX; grow_len(); return 1; end
        close_token(K_NUMBER, 8'd0, tok_len);
        return 0;
      end
      M_COMMENT: begin
        if (c == 8'd10 || c == 8'd13) scan_mode = M_IDLE;
        return 1;
      end
      M_LT: begin
        if (c == "=") begin close_token(K_BINOP, OP_LE, 16'd2); return 1; end
        close_token(K_BINOP, OP_LT, 16'd1);
        return 0;
      end
      M_GT: begin
        if (c == "=") begin close_token(K_BINOP, OP_GE, 16'd2); return 1; end
        close_token(K_BINOP, OP_GT, 16'd1);
        return 0;
      end
      M_EQ: begin
        if (c == "=") begin close_token(K_BINOP, OP_EQ, 16'd2); return 1; end
        close_token(K_ASSIGN, 8'd0, 16'd1);
        return 0;
      end
      M_BANG: begin
        if (c == "=") begin close_token(K_BINOP, OP_NE, 16'd2); return 1; end
        close_token(K_UNOP, 8'd0, 16'd1);
        return 0;
      end
      M_CH_OPEN: begin
        if (c == 8'd39) begin raise_error(E_EMPTY_CH, len_with_byte()); return 1; end
        grow_len();
        if (c == 8'd92) begin scan_mode = M_CH_ESC; return 1; end
        char_value = c;
        scan_mode = M_CH_CLOSE;
        return 1;
      end
      M_CH_ESC: begin
        if (c == "0") char_value = 8'd0;
        else if (c == "n") char_value = 8'd10;
        else if (c == 8'd39) char_value = 8'd39;
        else begin raise_error(E_BAD_ESC, len_with_byte()); return 1; end
        grow_len();
        scan_mode = M_CH_CLOSE;
        return 1;
      end
      M_CH_CLOSE: begin
        if (c == 8'd39) begin close_token(K_CHAR, char_value, len_with_byte()); return 1; end
        raise_error(E_NO_APOS, len_with_byte());
        return 1;
      end
      default: begin
        scan_mode = M_IDLE;
        return 0;
      end
    endcase
  endfunction

  function automatic void flush_at_end();
    case (scan_mode)
      M_IDENT: close_ident();
      M_ZERO, M_DEC, M_SUFFIX, M_HEX, M_BIN, M_OCT: close_token(K_NUMBER, 8'd0, tok_len);
      M_LT:    close_token(K_BINOP, OP_LT, 16'd1);
      M_GT:    close_token(K_BINOP, OP_GT, 16'd1);
      M_EQ:    close_token(K_ASSIGN, 8'd0, 16'd1);
      M_BANG:  close_token(K_UNOP, 8'd0, 16'd1);
      M_CH_OPEN, M_CH_CLOSE: raise_error(E_NO_APOS, tok_len);
      M_CH_ESC: raise_error(E_BAD_ESC, tok_len);
      default: scan_mode = M_IDLE;
    endcase
  endfunction

  function automatic void scanner_reset();
    scan_mode = M_IDLE;
    kw_alive = '0;
    tok_len = '0;
    tok_row = '0;
    tok_col = '0;
    cur_row = 16'd1;
    cur_col = '0;
    char_value = '0;
    halted = 1'b0;
  endfunction

  // advance the predictor by one accepted item and queue its tokens
  function automatic void predict_tokens(logic [7:0] c, logic eoi);
    logic [15:0] row, col;
    row = cur_row;
    col = cur_col;
    step_count = 0;
    if (halted) return;
    if (eoi) begin
      flush_at_end();
      if (!halted) put_token(K_EOF, 8'd0, cur_row, cur_col, 16'd0, E_NONE);
    end else begin
      if (c == 8'd10) begin
        if (cur_row != POS_MAX) cur_row++;
        cur_col = '0;
      end else if (cur_col != POS_MAX) begin
        cur_col++;
      end
      if (!extend_token(c) && !halted) open_token(c, row, col);
    end
    if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
    for (int i = 0; i < step_count; i++) pending_tokens = {pending_tokens, step_tokens[i]};
  endfunction

  // ---------------------------------------------------------------------
  // Token checker and receiver stalls
  // ---------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    token_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_tokens.size() == 0) begin
        $error("token_kind: expected none, got %0d", out_ch.token_kind);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", want.tok.kind, out_ch.token_kind);
        check_field("token_detail", want.tok.detail, out_ch.token_detail);
        check_field("start_row", want.tok.row, out_ch.start_row);
        check_field("start_column", want.tok.col, out_ch.start_column);
        check_field("token_length", want.tok.len, out_ch.token_length);
        check_field("error_code", want.tok.err, out_ch.error_code);
        check_field("last_of_run", want.last, out_ch.last_of_run);
      end
    end
    out_ch.ready <= (rst || $urandom_range(99) >= stall_rate);
  end

  // watchdog: any handshake clears the count
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  task automatic send_item(input logic [7:0] c, input logic eoi);
    if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.char_byte    <= c;
    in_ch.end_of_input <= eoi;
    do @(posedge clk); while (!in_ch.ready);
    predict_tokens(c, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // end mark carries a random byte that must be ignored
  task automatic send_end();
    send_item(8'($urandom), 1'b1);
  endtask

  task automatic drain_tokens();
    in_ch.valid <= 1'b0;
    wait (pending_tokens.size() == 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Random well-formed source: tokens always split by whitespace or comments
  // ---------------------------------------------------------------------
  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  function automatic void add_separator(ref logic [7:0] q[$]);
    string spaces;
    spaces = " \t\n\r";
    if ($urandom_range(7) == 0) begin
      q = {q, 8'd35};
      repeat ($urandom_range(0, 6)) begin
        logic [7:0] b;
        do b = 8'($urandom); while (b == 8'd10 || b == 8'd13);
        q = {q, b};
      end
      q = {q, ($urandom_range(1) ? 8'd10 : 8'd13)};
    end else begin
      repeat ($urandom_range(1, 2))
        q = {q, ($urandom_range(5) == 0 ? 8'($urandom_range(11, 12)) : pick(spaces))};
    end
  endfunction

  function automatic void add_token(ref logic [7:0] q[$]);
    string letters, digs, hexs, ops;
    int    n;
    logic [7:0] b;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    digs    = "0123456789";
    hexs    = "0123456789abcdefABCDEF_";
    case ($urandom_range(7))
      0: begin  // keyword, keyword prefix or keyword with tail
        string w;
        w = kw_words[$urandom_range(8)];
        n = $urandom_range(3) == 0 ? $urandom_range(1, w.len()) : w.len();
        for (int i = 0; i < n; i++) q = {q, 8'(w[i])};
        if ($urandom_range(3) == 0) q = {q, pick({letters, digs})};
      end
      1: begin  // identifier
        q = {q, ($urandom_range(9) == 0 ? 8'd64 : pick(letters))};
        repeat ($urandom_range(0, 8)) q = {q, pick({letters, digs})};
      end
      2: begin  // decimal with optional width suffix
        q = {q, pick(digs)};
        repeat ($urandom_range(0, 5)) q = {q, pick({digs, "._"})};
        if ($urandom_range(1)) begin
          q = {q, pick("iuf")};
          repeat ($urandom_range(0, 2)) q = {q, pick(digs)};
        end
      end
      3: begin  // prefixed number
        q = {q, 8'd48};
        b = pick("xbo");
        q = {q, b};
        repeat ($urandom_range(0, 5))
          q = {q, pick(b == "x" ? hexs : (b == "b" ? "01_" : "01234567_"))};
        if ($urandom_range(2) == 0) begin
          q = {q, pick("iu")};
          repeat ($urandom_range(0, 2)) q = {q, pick(digs)};
        end
      end
      4: begin  // char literal, plain or escaped
        q = {q, 8'd39};
        if ($urandom_range(3) == 0) begin
          q = {q, 8'd92};
          q = {q, pick("0n'")};
        end else begin
          do b = 8'($urandom); while (b == 8'd39 || b == 8'd92);
          q = {q, b};
        end
        q = {q, 8'd39};
      end
      default: begin  // punctuation and operators, some doubled
        ops = ";,{}():*/+-%<>=!";
        b = pick(ops);
        q = {q, b};
        if ((b == "<" || b == ">" || b == "=" || b == "!") && $urandom_range(1))
          q = {q, 8'd61};
      end
    endcase
  endfunction

  task automatic send_random_source(input int items);
    logic [7:0] q[$];
    int sent;
    sent = 0;
    while (sent < items) begin
      q.delete();
      add_token(q);
      add_separator(q);
      foreach (q[i]) send_item(q[i], 1'b0);
      sent += q.size();
      if ($urandom_range(39) == 0) begin
        send_end();
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_keywords();
    // exact keywords, then a prefix, an extension and a leading '@'
    send_text("fn pub ret var if else while break continue els continuex @x_9\n");
    send_end();
  endtask

  task automatic test_numbers();
    // adjacent tokens: a byte that ends one token starts the next
    send_text("0 7 12.5_f64 0x1F_aBu8 0b10_1i 0o777u16 42i7x 0x");
    send_end();
  endtask

  task automatic test_chars();
    send_text("'a' '\\0' '\\n' '\\'' '");
    send_item(8'hFF, 1'b0);
    send_text("''");
    send_item(8'h00, 1'b0);
    send_text("'");
    send_end();
  endtask

  task automatic test_operators();
    // "<x" style pairs emit the operator on the second byte, which starts the next token
    send_text(";,{}():*/+-%<<=>>===!=!<a>b=c!d");
    send_text("# comment with bytes ");
    send_item(8'h80, 1'b0);
    send_item(8'd13, 1'b0);
    send_text("<");
    send_end();
    send_text("# open comment at end");
    send_end();
  endtask

  task automatic test_random();
    sender_idle = 0;  stall_rate = 0;  send_random_source(400);
    sender_idle = 70; stall_rate = 0;  send_random_source(400);
    sender_idle = 0;  stall_rate = 70; send_random_source(400);
    sender_idle = 35; stall_rate = 35; send_random_source(400);
    send_end();
    sender_idle = 0;  stall_rate = 0;
  endtask

  task automatic test_long_runs();
    // hold off until the scanner has caught up, then a long identifier and blank lines
    drain_tokens();
    send_item("a", 1'b0);
    repeat (150) send_item("b", 1'b0);
    send_text(" 5 ");
    repeat (60) send_item(8'd10, 1'b0);
    send_text("x\n");
    send_end();
  endtask

  // one lexical error; the scanner then stays silent
  task automatic test_error_halt();
    string cases[11] = '{"0x1.", "0b12", "0b1.", "0o78", "0o7f", "''", "'\\q", "'ab",
                         "$", "'a", "'\\"};
    int pick_case;
    stall_rate = 35;
    pick_case = $urandom_range(10);
    send_text("ok ");
    if (pick_case == 8 && $urandom_range(1))
      send_item($urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'h00, 1'b0);
    else send_text(cases[pick_case]);
    if (pick_case >= 9) send_end();  // end of input inside a literal
    repeat (40) send_item(8'($urandom), 1'b0);
    send_end();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.char_byte = '0;
    in_ch.end_of_input = 1'b0;
    scanner_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_keywords();
    test_numbers();
    test_chars();
    test_operators();
    test_random();
    test_long_runs();
    test_error_halt();

    in_ch.valid <= 1'b0;
    wait (pending_tokens.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
`default_nettype wire
